/* hw/rtl/page_access_monitor_unit_macros.svh */
// Assertion macros for the page access monitor.
// Used by page_access_monitor_unit; relies on ports named clock and reset.
`ifndef PAGE_ACCESS_MONITOR_UNIT_MACROS_SVH
`define PAGE_ACCESS_MONITOR_UNIT_MACROS_SVH

// same-cycle implication
`define PAM_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define PAM_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* hw/rtl/pam_pkg.sv */
// Shared constants, widths and control structs of the page access monitor.
// No dependencies; imported by pam_marker, page_access_monitor_unit and the testbench.
package pam_pkg;

   localparam int TRACKED_PAGES = 65536;
   localparam int PAGE_SIZE     = 4096;

   localparam int OFFSET_W = 40;
   localparam int AMOUNT_W = 17;
   localparam int FSIZE_W  = 41;
   localparam int READ_W   = 32;
   localparam int BYTE_W   = 48;
   localparam int DIST_W   = 17;

   localparam int PAGE_SHIFT = $clog2(PAGE_SIZE);
   localparam int PAGE_NUM_W = FSIZE_W - PAGE_SHIFT;
   localparam int PAGE_IX_W  = $clog2(TRACKED_PAGES);

   localparam int MAP_WIDTH = (TRACKED_PAGES / 2 < 64) ? TRACKED_PAGES / 2 : 64;
   localparam int MAP_COL_W = $clog2(MAP_WIDTH);
   localparam int MAP_ROWS  = TRACKED_PAGES / MAP_WIDTH;
   localparam int MAP_ROW_W = $clog2(MAP_ROWS);

   localparam int REQ_TDATA_W = ((OFFSET_W + AMOUNT_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * AMOUNT_W + READ_W + BYTE_W + DIST_W;
   localparam int RSP_TDATA_W = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef struct packed {
      logic                 start;
      logic                 clear;
      logic [PAGE_IX_W-1:0] first;
      logic [PAGE_IX_W-1:0] last;
   } mark_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic hit;
   } mark_stat_type;

endpackage

/* hw/rtl/pam_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pam_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/pam_marker.sv */
// Page bitmap engine: clearing sweep and read-modify-write marking of a page range.
// Depends on pam_pkg and pam_ram.
module pam_marker (
   input  logic                   clock,
   input  logic                   reset,
   input  pam_pkg::mark_cmd_type  cmd,
   output pam_pkg::mark_stat_type stat
);
   import pam_pkg::*;

   typedef enum logic [1:0] {M_IDLE, M_CLEAR, M_RUN, M_DRAIN} mstate_type;

   mstate_type           state_ff, state_in;
   logic [MAP_ROW_W-1:0] clr_row_ff, clr_row_in;
   logic [PAGE_IX_W-1:0] pg_ff, pg_in;
   logic [PAGE_IX_W-1:0] last_ff, last_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [PAGE_IX_W-1:0] rd_pg_ff, rd_pg_in;
   logic                 fwd_vld_ff, fwd_vld_in;
   logic [MAP_ROW_W-1:0] fwd_row_ff, fwd_row_in;
   logic [MAP_WIDTH-1:0] fwd_data_ff, fwd_data_in;
   logic                 done_ff, done_in;
   logic                 hit_ff, hit_in;

   logic                 ram_we;
   logic [MAP_ROW_W-1:0] ram_waddr;
   logic [MAP_WIDTH-1:0] ram_wdata;
   logic [MAP_ROW_W-1:0] ram_raddr;
   logic [MAP_WIDTH-1:0] ram_rdata;

   logic [MAP_ROW_W-1:0] rd_row;
   logic [MAP_WIDTH-1:0] row_data;
   logic [MAP_WIDTH-1:0] bit_mask;

   pam_ram #(
      .WIDTH(MAP_WIDTH),
      .DEPTH(MAP_ROWS)
   ) u_map_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd_row    = rd_pg_ff[PAGE_IX_W-1:MAP_COL_W];
   assign ram_raddr = pg_ff[PAGE_IX_W-1:MAP_COL_W];
   assign bit_mask  = MAP_WIDTH'(1) << rd_pg_ff[MAP_COL_W-1:0];
   assign row_data  = (fwd_vld_ff && fwd_row_ff == rd_row) ? fwd_data_ff : ram_rdata;

   always_comb begin
      state_in    = state_ff;
      clr_row_in  = clr_row_ff;
      pg_in       = pg_ff;
      last_in     = last_ff;
      rd_vld_in   = 1'b0;
      rd_pg_in    = rd_pg_ff;
      fwd_vld_in  = fwd_vld_ff;
      fwd_row_in  = fwd_row_ff;
      fwd_data_in = fwd_data_ff;
      done_in     = 1'b0;
      hit_in      = 1'b0;
      ram_we      = 1'b0;
      ram_waddr   = rd_row;
      ram_wdata   = row_data | bit_mask;

      if (rd_vld_ff) begin
         ram_we      = 1'b1;
         hit_in      = ~|(row_data & bit_mask);
         fwd_vld_in  = 1'b1;
         fwd_row_in  = rd_row;
         fwd_data_in = row_data | bit_mask;
      end

      case (state_ff)
         M_IDLE: begin
            if (cmd.clear) begin
               clr_row_in = '0;
               state_in   = M_CLEAR;
            end else if (cmd.start) begin
               pg_in    = cmd.first;
               last_in  = cmd.last;
               state_in = M_RUN;
            end
         end
         M_CLEAR: begin
            ram_we     = 1'b1;
            ram_waddr  = clr_row_ff;
            ram_wdata  = '0;
            fwd_vld_in = 1'b0;
            clr_row_in = clr_row_ff + MAP_ROW_W'(1);
            if (clr_row_ff == MAP_ROW_W'(MAP_ROWS - 1)) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         M_RUN: begin
            rd_vld_in = 1'b1;
            rd_pg_in  = pg_ff;
            if (pg_ff == last_ff) begin
               state_in = M_DRAIN;
            end else begin
               pg_in = pg_ff + PAGE_IX_W'(1);
            end
         end
         M_DRAIN: begin
            if (!rd_vld_ff) begin
               done_in  = 1'b1;
               state_in = M_IDLE;
            end
         end
         default: begin
            state_in = M_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= M_CLEAR;
         clr_row_ff <= '0;
         rd_vld_ff  <= 1'b0;
         fwd_vld_ff <= 1'b0;
         done_ff    <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
         rd_vld_ff  <= rd_vld_in;
         fwd_vld_ff <= fwd_vld_in;
         done_ff    <= done_in;
         hit_ff     <= hit_in;
      end
      pg_ff       <= pg_in;
      last_ff     <= last_in;
      rd_pg_ff    <= rd_pg_in;
      fwd_row_ff  <= fwd_row_in;
      fwd_data_ff <= fwd_data_in;
   end

   assign stat.busy = (state_ff != M_IDLE);
   assign stat.done = done_ff;
   assign stat.hit  = hit_ff;

endmodule

/* hw/rtl/page_access_monitor_unit.sv */
// Page access monitor: read clipping, statistics counters and page tracking.
// Depends on pam_pkg, pam_marker and page_access_monitor_unit_macros.svh.
// Usage:
//   req channel carries one transaction per command: tuser is the mode
//   (0 = read, 1 = clear statistics), tdata holds offset and amount.
//   rsp channel returns one transaction per command: tuser is the status
//   (1 = short read), tdata holds fetch length, zero fill and the counters.
//   csr_wen/csr_wdata set the file size; write it only while the block is idle.
// Sequence:
//   A read is clipped and counted, then the tracked pages it covers (at most
//   17 for a 64 KiB read) are marked in the bitmap; one page per cycle goes
//   through the bitmap RAM. A read inside the file that marks no page skips
//   the bitmap (empty range, or range beyond the map). A read at or past the
//   end skips the counters and the bitmap.
//   A clear sweeps all MAP_ROWS (1024) rows of the bitmap.
//   One command is processed at a time; the next is accepted the cycle after
//   the result enters the output register, even if the receiver has not taken it.
// Reset: counters and file size go to zero and the bitmap is swept clear,
//   during which req_tready stays low.
// Stall: a held result blocks only the completion of the following command.
`include "page_access_monitor_unit_macros.svh"

module page_access_monitor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [39:0] offset, [56:40] amount, [63:57] zero
   input  logic [pam_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] mode
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [16:0] fetch_length, [33:17] zero_fill, [65:34] read_total,
   // [113:66] byte_sum, [130:114] distinct_count, [135:131] zero
   output logic [pam_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [0] status
   output logic                            rsp_tuser,
   input  logic                            csr_wen,
   input  logic [pam_pkg::FSIZE_W-1:0]     csr_wdata
);
   import pam_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CLIP, ST_SIZE, ST_ADD, ST_LIMIT, ST_WAIT, ST_OUT
   } state_type;

   state_type             state_ff, state_in;
   logic [FSIZE_W-1:0]    fsize_ff, fsize_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [AMOUNT_W-1:0]   amount_ff, amount_in;
   logic                  past_ff, past_in;
   logic [FSIZE_W-1:0]    room_ff, room_in;
   logic                  status_ff, status_in;
   logic [AMOUNT_W-1:0]   fetch_ff, fetch_in;
   logic [AMOUNT_W-1:0]   fill_ff, fill_in;
   logic [PAGE_NUM_W-1:0] first_ff, first_in;
   logic [PAGE_NUM_W-1:0] last_ff, last_in;
   logic [READ_W-1:0]     read_cnt_ff, read_cnt_in;
   logic [BYTE_W-1:0]     byte_cnt_ff, byte_cnt_in;
   logic [DIST_W-1:0]     dist_cnt_ff, dist_cnt_in;
   mark_cmd_type          cmd_ff, cmd_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   mark_stat_type         stat;
   logic                  req_accept;
   logic [FSIZE_W-1:0]    end_addr;

   pam_marker u_marker (
      .clock(clock),
      .reset(reset),
      .cmd  (cmd_ff),
      .stat (stat)
   );

   assign req_tready = (state_ff == ST_IDLE) && !stat.busy;
   assign req_accept = req_tvalid && req_tready;
   assign end_addr   = FSIZE_W'(offset_ff) + FSIZE_W'(fetch_ff) - FSIZE_W'(1);

   always_comb begin
      state_in      = state_ff;
      fsize_in      = fsize_ff;
      offset_in     = offset_ff;
      amount_in     = amount_ff;
      past_in       = past_ff;
      room_in       = room_ff;
      status_in     = status_ff;
      fetch_in      = fetch_ff;
      fill_in       = fill_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      read_cnt_in   = read_cnt_ff;
      byte_cnt_in   = byte_cnt_ff;
      dist_cnt_in   = dist_cnt_ff;
      cmd_in        = '0;
      cmd_in.first  = cmd_ff.first;
      cmd_in.last   = cmd_ff.last;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;

      if (csr_wen) begin
         fsize_in = csr_wdata;
      end
      if (stat.hit) begin
         dist_cnt_in = dist_cnt_ff + DIST_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               offset_in = req_tdata[OFFSET_W-1:0];
               amount_in = req_tdata[OFFSET_W+AMOUNT_W-1:OFFSET_W];
               if (req_tuser) begin
                  cmd_in.clear = 1'b1;
                  read_cnt_in  = '0;
                  byte_cnt_in  = '0;
                  dist_cnt_in  = '0;
                  status_in    = 1'b0;
                  fetch_in     = '0;
                  fill_in      = '0;
                  state_in     = ST_WAIT;
               end else begin
                  state_in = ST_CLIP;
               end
            end
         end
         ST_CLIP: begin
            past_in  = FSIZE_W'(offset_ff) >= fsize_ff;
            room_in  = fsize_ff - FSIZE_W'(offset_ff);
            state_in = ST_SIZE;
         end
         ST_SIZE: begin
            if (past_ff) begin
               status_in = 1'b1;
               fetch_in  = '0;
               fill_in   = amount_ff;
               state_in  = ST_OUT;
            end else begin
               if (FSIZE_W'(amount_ff) > room_ff) begin
                  status_in = 1'b1;
                  fetch_in  = room_ff[AMOUNT_W-1:0];
                  fill_in   = amount_ff - room_ff[AMOUNT_W-1:0];
               end else begin
                  status_in = 1'b0;
                  fetch_in  = amount_ff;
                  fill_in   = '0;
               end
               read_cnt_in = read_cnt_ff + READ_W'(1);
               state_in    = ST_ADD;
            end
         end
         ST_ADD: begin
            byte_cnt_in = byte_cnt_ff + BYTE_W'(fetch_ff);
            first_in    = PAGE_NUM_W'(offset_ff >> PAGE_SHIFT);
            last_in     = end_addr[FSIZE_W-1:PAGE_SHIFT];
            state_in    = (fetch_ff == '0) ? ST_OUT : ST_LIMIT;
         end
         ST_LIMIT: begin
            if (first_ff >= PAGE_NUM_W'(TRACKED_PAGES)) begin
               state_in = ST_OUT;
            end else begin
               cmd_in.start = 1'b1;
               cmd_in.first = first_ff[PAGE_IX_W-1:0];
               cmd_in.last  = (last_ff >= PAGE_NUM_W'(TRACKED_PAGES)) ?
                              PAGE_IX_W'(TRACKED_PAGES - 1) : last_ff[PAGE_IX_W-1:0];
               state_in     = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (stat.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = RSP_TDATA_W'({dist_cnt_ff, byte_cnt_ff, read_cnt_ff,
                                             fill_ff, fetch_ff});
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fsize_ff     <= '0;
         read_cnt_ff  <= '0;
         byte_cnt_ff  <= '0;
         dist_cnt_ff  <= '0;
         cmd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fsize_ff     <= fsize_in;
         read_cnt_ff  <= read_cnt_in;
         byte_cnt_ff  <= byte_cnt_in;
         dist_cnt_ff  <= dist_cnt_in;
         cmd_ff       <= cmd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      offset_ff     <= offset_in;
      amount_ff     <= amount_in;
      past_ff       <= past_in;
      room_ff       <= room_in;
      status_ff     <= status_in;
      fetch_ff      <= fetch_in;
      fill_ff       <= fill_in;
      first_ff      <= first_in;
      last_ff       <= last_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = rsp_data_ff;

   `PAM_ASSERT_IMPL(a_busy_blocks_req, stat.busy, !req_tready)
   `PAM_ASSERT_NEXT(a_accept_closes_req, req_accept, !req_tready)
   `PAM_ASSERT_IMPL(a_full_read_no_fill, rsp_tvalid && !rsp_tuser,
                    rsp_tdata[2*AMOUNT_W-1:AMOUNT_W] == '0)
   `PAM_ASSERT_IMPL(a_hit_only_waiting, stat.hit, state_ff == ST_WAIT)

endmodule

/* tb/testbench.sv */
// Self-checking testbench for page_access_monitor_unit: directed and random
// read/clear commands against a cycle-free model of clipping, counters and page map.
// Depends on pam_pkg and the page_access_monitor_unit RTL.
`timescale 1ns / 1ps

module testbench;
   import pam_pkg::*;

   localparam logic MODE_READ    = 1'b0;
   localparam logic MODE_CLEAR   = 1'b1;
   localparam logic STATUS_FULL  = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   localparam int FETCH_LO = 0;
   localparam int FILL_LO  = FETCH_LO + AMOUNT_W;
   localparam int READS_LO = FILL_LO + AMOUNT_W;
   localparam int BYTES_LO = READS_LO + READ_W;
   localparam int DIST_LO  = BYTES_LO + BYTE_W;

   localparam longint unsigned FILE_MAX   = 64'd1 << OFFSET_W;
   localparam longint unsigned MAP_EDGE   = longint'(TRACKED_PAGES) * PAGE_SIZE;
   localparam int              STALL_LIMIT = 8000;
   localparam int              DRAIN_CYCLES = 40;
   localparam int              QUIET_FIRST = 150;
   localparam int              QUIET_LAST  = 260;

   typedef enum logic {ENTRY_COMMAND, ENTRY_FILE_SIZE} entry_kind_type;

   typedef struct {
      entry_kind_type      kind;
      logic                mode;
      logic [OFFSET_W-1:0] offset;
      logic [AMOUNT_W-1:0] amount;
      logic [FSIZE_W-1:0]  file_size;
   } command_entry_type;

   typedef struct packed {
      logic                status;
      logic [AMOUNT_W-1:0] fetch_length;
      logic [AMOUNT_W-1:0] zero_fill;
      logic [READ_W-1:0]   read_total;
      logic [BYTE_W-1:0]   byte_sum;
      logic [DIST_W-1:0]   distinct_count;
   } clip_report_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wen = 1'b0;
   logic [FSIZE_W-1:0]     csr_wdata = '0;

   command_entry_type command_queue[$];
   clip_report_type   clip_reports[$];

   logic [FSIZE_W-1:0]       served_size = '0;
   logic [READ_W-1:0]        reads_seen = '0;
   logic [BYTE_W-1:0]        bytes_seen = '0;
   logic [DIST_W-1:0]        pages_seen = '0;
   bit [TRACKED_PAGES-1:0]   page_touched = '0;

   int req_count = 0;
   int rsp_count = 0;
   int error_count = 0;
   int stall_cycles = 0;

   page_access_monitor_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what);
      if (error_count < 100) $display("MISMATCH at %0t: %s", $time, what);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want, input int index);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got 0x%0h, expected 0x%0h",
                                   index, name, got, want));
   endtask

   task automatic clip_and_count(input logic mode, input logic [OFFSET_W-1:0] offset,
                                 input logic [AMOUNT_W-1:0] amount);
      clip_report_type   rep;
      longint unsigned   room;
      longint unsigned   fetch;
      longint unsigned   first_pg;
      longint unsigned   last_pg;
      longint unsigned   pg;
      rep = '0;
      if (mode == MODE_CLEAR) begin
         reads_seen   = '0;
         bytes_seen   = '0;
         pages_seen   = '0;
         page_touched = '0;
      end else if (longint'(offset) >= longint'(served_size)) begin
         rep.status    = STATUS_SHORT;
         rep.zero_fill = amount;
      end else begin
         room  = longint'(served_size) - longint'(offset);
         fetch = (longint'(amount) > room) ? room : longint'(amount);
         rep.fetch_length = fetch[AMOUNT_W-1:0];
         rep.zero_fill    = amount - fetch[AMOUNT_W-1:0];
         rep.status       = (rep.zero_fill != 0) ? STATUS_SHORT : STATUS_FULL;
         reads_seen = reads_seen + 1'b1;
         bytes_seen = bytes_seen + fetch[BYTE_W-1:0];
         if (fetch != 0) begin
            first_pg = longint'(offset) / PAGE_SIZE;
            last_pg  = (longint'(offset) + fetch - 1) / PAGE_SIZE;
            for (pg = first_pg; pg <= last_pg && pg < TRACKED_PAGES; pg++) begin
               if (!page_touched[pg[PAGE_IX_W-1:0]]) begin
                  page_touched[pg[PAGE_IX_W-1:0]] = 1'b1;
                  pages_seen = pages_seen + 1'b1;
               end
            end
         end
      end
      rep.read_total     = reads_seen;
      rep.byte_sum       = bytes_seen;
      rep.distinct_count = pages_seen;
      clip_reports.push_back(rep);
   endtask

   // driver
   always @(posedge clock) begin : drive_commands
      int   sent;
      logic valid_next;
      logic wen_next;
      logic gap;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_wen    <= 1'b0;
      end else begin
         sent       = req_count;
         valid_next = req_tvalid;
         wen_next   = 1'b0;
         gap = !(req_count >= QUIET_FIRST && req_count < QUIET_LAST) &&
               ($urandom_range(0, 99) < 25);
         if (req_tvalid && req_tready) begin
            clip_and_count(req_tuser, req_tdata[OFFSET_W-1:0],
                           req_tdata[OFFSET_W +: AMOUNT_W]);
            sent++;
            req_count <= sent;
         end
         if (!req_tvalid || req_tready) begin
            valid_next = 1'b0;
            if (command_queue.size() != 0) begin
               if (command_queue[0].kind == ENTRY_FILE_SIZE) begin
                  // hold until every response is back
                  if (sent == rsp_count) begin
                     wen_next    = 1'b1;
                     csr_wdata   <= command_queue[0].file_size;
                     served_size = command_queue[0].file_size;
                     void'(command_queue.pop_front());
                  end
               end else if (!gap) begin
                  valid_next = 1'b1;
                  req_tuser  <= command_queue[0].mode;
                  req_tdata  <= {{(REQ_TDATA_W - OFFSET_W - AMOUNT_W){1'b0}},
                                 command_queue[0].amount, command_queue[0].offset};
                  void'(command_queue.pop_front());
               end
            end
         end
         req_tvalid <= valid_next;
         csr_wen    <= wen_next;
      end
   end

   // monitor
   always @(posedge clock) begin : check_responses
      clip_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (clip_reports.size() == 0) begin
               report_mismatch($sformatf("response %0d with no command outstanding",
                                         rsp_count));
            end else begin
               want = clip_reports.pop_front();
               compare_field("status", rsp_tuser, want.status, rsp_count);
               compare_field("fetch_length", rsp_tdata[FETCH_LO +: AMOUNT_W],
                             want.fetch_length, rsp_count);
               compare_field("zero_fill", rsp_tdata[FILL_LO +: AMOUNT_W],
                             want.zero_fill, rsp_count);
               compare_field("read_total", rsp_tdata[READS_LO +: READ_W],
                             want.read_total, rsp_count);
               compare_field("byte_sum", rsp_tdata[BYTES_LO +: BYTE_W],
                             want.byte_sum, rsp_count);
               compare_field("distinct_count", rsp_tdata[DIST_LO +: DIST_W],
                             want.distinct_count, rsp_count);
            end
            rsp_count <= rsp_count + 1;
         end
         rsp_tready <= (rsp_count >= QUIET_FIRST && rsp_count < QUIET_LAST) ||
                       ($urandom_range(0, 99) >= 25);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wen) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   task automatic push_read(input logic [OFFSET_W-1:0] offset,
                            input logic [AMOUNT_W-1:0] amount);
      command_queue.push_back('{ENTRY_COMMAND, MODE_READ, offset, amount, '0});
   endtask

   task automatic push_clear(input logic [OFFSET_W-1:0] offset,
                             input logic [AMOUNT_W-1:0] amount);
      command_queue.push_back('{ENTRY_COMMAND, MODE_CLEAR, offset, amount, '0});
   endtask

   task automatic push_file_size(input logic [FSIZE_W-1:0] value);
      command_queue.push_back('{ENTRY_FILE_SIZE, MODE_READ, '0, '0, value});
   endtask

   function automatic logic [FSIZE_W-1:0] pick_file_size(input int phase);
      case (phase)
         0, 7:    return FSIZE_W'(FILE_MAX);
         1, 6:    return FSIZE_W'($urandom_range(1, 1 << 20));
         3:       return FSIZE_W'(MAP_EDGE - 65536 + $urandom_range(0, 131072));
         5:       return FSIZE_W'({$urandom_range(0, 511), $urandom()});
         default: return FSIZE_W'({$urandom_range(0, 255), $urandom()});
      endcase
   endfunction

   function automatic logic [AMOUNT_W-1:0] pick_amount();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5)  return '0;
      if (r < 15) return AMOUNT_W'($urandom_range(65537, 131071));
      if (r < 25) return AMOUNT_W'(65536 - $urandom_range(0, 3));
      if (r < 60) return AMOUNT_W'($urandom_range(1, 8192));
      return AMOUNT_W'($urandom_range(1, 65536));
   endfunction

   function automatic logic [OFFSET_W-1:0] pick_offset(input logic [FSIZE_W-1:0] fsize);
      int              r;
      longint unsigned back;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         back = 64'($urandom_range(0, 70000));
         return OFFSET_W'((longint'(fsize) > back) ? longint'(fsize) - back : 64'd0);
      end
      if (r < 70) return OFFSET_W'($urandom_range(0, 1 << 20));
      if (r < 85) return OFFSET_W'(MAP_EDGE - 70000 + $urandom_range(0, 140000));
      return OFFSET_W'({$urandom_range(0, 255), $urandom()});
   endfunction

   initial begin
      logic [FSIZE_W-1:0] fsize;
      // file size still at its reset value
      push_read(40'd0, 17'd5);
      push_file_size(FSIZE_W'(FILE_MAX));
      push_read(40'd0, 17'd0);
      push_read(40'd100, 17'd65536);
      push_read(40'd100, 17'd65536);
      push_read({OFFSET_W{1'b1}}, {AMOUNT_W{1'b1}});
      push_read(OFFSET_W'(MAP_EDGE - PAGE_SIZE), 17'd8192);
      push_read(OFFSET_W'(MAP_EDGE), 17'd100);
      push_clear({OFFSET_W{1'b1}}, {AMOUNT_W{1'b1}});
      push_read(40'd5000, 17'd10);
      push_file_size(41'd10000);
      push_read(40'd9000, 17'd4000);
      push_read(40'd10000, 17'd1);
      push_read(40'd20000, 17'd300);
      push_read(40'd0, 17'd10000);
      push_read(40'd4095, 17'd2);
      push_file_size({FSIZE_W{1'b1}});
      push_read({OFFSET_W{1'b1}}, 17'd65536);
      push_read(40'd0, 17'd65537);
      push_clear(40'd0, 17'd0);
      push_read(40'd12345, 17'd4096);
      push_file_size('0);
      push_read(40'd0, 17'd0);
      push_read(40'd7, 17'd8);

      for (int phase = 0; phase < 8; phase++) begin
         fsize = pick_file_size(phase);
         push_file_size(fsize);
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 3)
               push_clear(OFFSET_W'({$urandom_range(0, 255), $urandom()}),
                          AMOUNT_W'($urandom_range(0, 131071)));
            else
               push_read(pick_offset(fsize), pick_amount());
         end
      end

      // drain
      while (command_queue.size() != 0 || req_tvalid || req_count != rsp_count)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (clip_reports.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", clip_reports.size()));
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

/* page_access_monitor_unit.f */
+incdir+hw/rtl
hw/rtl/pam_pkg.sv
hw/rtl/pam_ram.sv
hw/rtl/pam_marker.sv
hw/rtl/page_access_monitor_unit.sv
tb/testbench.sv
